// File: hdl/bhr_pkg.sv
package bhr_pkg;

   // field widths fixed by the transaction format
   localparam int OPCODE_W    = 2;
   localparam int NODE_W      = 6;
   localparam int HOP_W       = 8;
   localparam int NODE_COUNT_W = 7;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY    = 2'd2;

   // node_count after reset
   localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [NODE_W-1:0]   start_node;
      logic [NODE_W-1:0]   target_node;
      logic [HOP_W-1:0]    hop_limit;
   } req_type;

   typedef struct packed {
      logic reachable;
      logic all_linked;
   } rsp_type;

   // control from the sequencer to the adjacency memory
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_RD_S,
      ST_EDGE_WR_S,
      ST_EDGE_RD_T,
      ST_EDGE_WR_T,
      ST_QUERY,
      ST_FINISH
   } state_type;

endpackage

// File: hdl/bounded_hop_reachability.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------
// req      | in        | req_valid / req_ready     | req_payload (opcode, nodes, hops)
// rsp      | out       | rsp_valid / rsp_ready     | rsp_payload (reachable, all_linked)
// csr      | in        | csr_wr_en, no wait        | csr_wr_data (node_count)
//
// clear and unused opcodes go straight to the result; an add edge does two
// read-modify-writes on the adjacency memory, one per end node; a query reads one row
// per cycle, but none at a level end, and this row read sets the query time
// reset is synchronous and empties the graph at once through per-row valid bits,
// so there is no clearing pass; clear does the same
// one transaction in work at a time; a new one is taken while a result waits
module bounded_hop_reachability #(
   parameter int NODES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bhr_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bhr_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [bhr_pkg::NODE_COUNT_W-1:0]    csr_wr_data
);

   localparam int IDX_W = $clog2(NODES);

   bhr_pkg::state_type state_ff, state_in;
   bhr_pkg::mem_ctl_type mem_ctl;

   logic [IDX_W-1:0] s_idx_ff, s_idx_in;
   logic [IDX_W-1:0] t_idx_ff, t_idx_in;
   logic [IDX_W-1:0] limit_ff, limit_in;
   logic [IDX_W-1:0] level_ff, level_in;
   logic [NODES-1:0] visited_ff, visited_in;
   logic [NODES-1:0] cur_ff, cur_in;
   logic [NODES-1:0] nxt_ff, nxt_in;
   logic [NODES-1:0] linked_ff, linked_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             reach_ff, reach_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bhr_pkg::rsp_type rsp_ff, rsp_in;
   logic [bhr_pkg::NODE_COUNT_W-1:0] node_count_ff, node_count_in;

   logic [IDX_W-1:0] rd_addr, wr_addr, pick_idx;
   logic [IDX_W-1:0] req_s_idx, req_t_idx;
   logic [NODES-1:0] rd_data, wr_data;
   logic [NODES-1:0] one_s, one_t, req_one_s, req_one_t;
   logic [NODES-1:0] lowest, row_merge, chk_mask;
   logic [IDX_W:0]   level_nx;
   logic             req_fire, s_ok, t_ok, same_node;
   logic             edge_go, query_go;
   logic             hit, cur_empty, lvl_end, q_fail;
   logic             slot_free, rsp_load, all_linked_now;

   // adjacency store
   bhr_adj_mem #(
      .NODES(NODES)
   ) u_adj_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // decode of the incoming transaction
   assign req_fire  = req_valid && req_ready;
   assign req_s_idx = IDX_W'(req_payload.start_node);
   assign req_t_idx = IDX_W'(req_payload.target_node);
   assign s_ok      = 32'(req_payload.start_node) < NODES;
   assign t_ok      = 32'(req_payload.target_node) < NODES;
   assign same_node = req_payload.start_node == req_payload.target_node;
   assign edge_go   = s_ok && t_ok;
   assign query_go  = !same_node && s_ok && t_ok && (req_payload.hop_limit != '0);

   // one-hot node vectors
   always_comb begin
      one_s     = '0;
      one_t     = '0;
      req_one_s = '0;
      req_one_t = '0;
      one_s[s_idx_ff]      = 1'b1;
      one_t[t_idx_ff]      = 1'b1;
      req_one_s[req_s_idx] = 1'b1;
      req_one_t[req_t_idx] = 1'b1;
   end

   // lowest pending frontier node and its index
   assign lowest = cur_ff & (~cur_ff + {{(NODES-1){1'b0}}, 1'b1});
   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < NODES; i++) begin
         if (lowest[i]) begin
            pick_idx = pick_idx | IDX_W'(i);
         end
      end
   end

   // frontier status
   assign hit       = visited_ff[t_idx_ff];
   assign cur_empty = cur_ff == '0;
   assign lvl_end   = cur_empty && !rd_pend_ff;
   assign level_nx  = {1'b0, level_ff} + (IDX_W+1)'(1);
   assign q_fail    = lvl_end && ((nxt_ff == '0) || (level_nx == {1'b0, limit_ff}));
   assign row_merge = rd_pend_ff ? rd_data : {NODES{1'b0}};

   // every node below node_count must have an edge
   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         chk_mask[i] = i < int'(node_count_ff);
      end
   end
   assign all_linked_now = &(linked_ff | ~chk_mask);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bhr_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_payload.opcode)
                  bhr_pkg::OP_ADD_EDGE: begin
                     state_in = edge_go ? bhr_pkg::ST_EDGE_RD_S : bhr_pkg::ST_FINISH;
                  end
                  bhr_pkg::OP_QUERY: begin
                     state_in = query_go ? bhr_pkg::ST_QUERY : bhr_pkg::ST_FINISH;
                  end
                  default: begin
                     state_in = bhr_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         bhr_pkg::ST_EDGE_RD_S: state_in = bhr_pkg::ST_EDGE_WR_S;
         bhr_pkg::ST_EDGE_WR_S: state_in = bhr_pkg::ST_EDGE_RD_T;
         bhr_pkg::ST_EDGE_RD_T: state_in = bhr_pkg::ST_EDGE_WR_T;
         bhr_pkg::ST_EDGE_WR_T: state_in = bhr_pkg::ST_FINISH;
         bhr_pkg::ST_QUERY: begin
            if (hit || q_fail) begin
               state_in = bhr_pkg::ST_FINISH;
            end
         end
         bhr_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = bhr_pkg::ST_IDLE;
            end
         end
         default: state_in = bhr_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake and memory port control
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mem_ctl   = '0;
      rd_addr   = s_idx_ff;
      wr_addr   = s_idx_ff;
      wr_data   = rd_data | one_t;
      case (state_ff)
         bhr_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            mem_ctl.clear = req_fire && (req_payload.opcode == bhr_pkg::OP_CLEAR);
         end
         bhr_pkg::ST_EDGE_RD_S: begin
            mem_ctl.rd_en = 1'b1;
         end
         bhr_pkg::ST_EDGE_WR_S: begin
            mem_ctl.wr_en = 1'b1;
         end
         bhr_pkg::ST_EDGE_RD_T: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = t_idx_ff;
         end
         bhr_pkg::ST_EDGE_WR_T: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = t_idx_ff;
            wr_data       = rd_data | one_s;
         end
         bhr_pkg::ST_QUERY: begin
            mem_ctl.rd_en = !hit && !cur_empty;
            rd_addr       = pick_idx;
         end
         bhr_pkg::ST_FINISH: begin
            rsp_load = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      s_idx_in      = s_idx_ff;
      t_idx_in      = t_idx_ff;
      limit_in      = limit_ff;
      level_in      = level_ff;
      visited_in    = visited_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      linked_in     = linked_ff;
      rd_pend_in    = rd_pend_ff;
      reach_in      = reach_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;

      // transaction start
      if (req_fire) begin
         s_idx_in   = req_s_idx;
         t_idx_in   = req_t_idx;
         reach_in   = (req_payload.opcode == bhr_pkg::OP_QUERY) && same_node;
         visited_in = req_one_s;
         cur_in     = req_one_s;
         nxt_in     = '0;
         level_in   = '0;
         rd_pend_in = 1'b0;
         if (32'(req_payload.hop_limit) > NODES - 1) begin
            limit_in = IDX_W'(NODES - 1);
         end else begin
            limit_in = IDX_W'(req_payload.hop_limit);
         end
         if (req_payload.opcode == bhr_pkg::OP_CLEAR) begin
            linked_in = '0;
         end else if ((req_payload.opcode == bhr_pkg::OP_ADD_EDGE) && edge_go) begin
            linked_in = linked_ff | req_one_s | req_one_t;
         end
      end

      // frontier expansion: merge the row read last cycle, issue the next read
      if ((state_ff == bhr_pkg::ST_QUERY) && !hit) begin
         visited_in = visited_ff | row_merge;
         nxt_in     = nxt_ff | (row_merge & ~visited_ff);
         rd_pend_in = !cur_empty;
         if (!cur_empty) begin
            cur_in = cur_ff & ~lowest;
         end else if (lvl_end && !q_fail) begin
            cur_in   = nxt_ff;
            nxt_in   = '0;
            level_in = level_nx[IDX_W-1:0];
         end
      end
      if ((state_ff == bhr_pkg::ST_QUERY) && hit) begin
         reach_in = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.reachable  = reach_ff;
         rsp_in.all_linked = all_linked_now;
         rsp_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bhr_pkg::ST_IDLE;
         linked_ff     <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= bhr_pkg::NODE_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         linked_ff     <= linked_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s_idx_ff   <= s_idx_in;
      t_idx_ff   <= t_idx_in;
      limit_ff   <= limit_in;
      level_ff   <= level_in;
      visited_ff <= visited_in;
      cur_ff     <= cur_in;
      nxt_ff     <= nxt_in;
      reach_ff   <= reach_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.rd_en && mem_ctl.wr_en))
      else $error("adjacency memory read and written in one cycle");

   a_frontier_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhr_pkg::ST_QUERY) |-> ((cur_ff & ~visited_ff) == '0))
      else $error("frontier node outside the visited set");

   a_next_visited: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhr_pkg::ST_QUERY) |-> ((nxt_ff & ~visited_ff) == '0))
      else $error("next level node outside the visited set");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bhr_pkg::ST_QUERY) |-> (level_ff < limit_ff))
      else $error("query level reached the hop limit");

   a_self_query: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.opcode == bhr_pkg::OP_QUERY) && same_node)
      |=> ((state_ff == bhr_pkg::ST_FINISH) && reach_ff))
      else $error("query to its own start node not answered at once");

endmodule

// File: hdl/bhr_adj_mem.sv
module bhr_adj_mem #(
   parameter int NODES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bhr_pkg::mem_ctl_type       mem_ctl,
   input  logic [$clog2(NODES)-1:0]   rd_addr,
   output logic [NODES-1:0]           rd_data,
   input  logic [$clog2(NODES)-1:0]   wr_addr,
   input  logic [NODES-1:0]           wr_data
);

   logic [NODES-1:0] rows [NODES];
   logic [NODES-1:0] row_valid_ff;
   logic [NODES-1:0] row_valid_in;
   logic [NODES-1:0] rd_row_ff;
   logic             rd_valid_ff;
   logic             rd_valid_in;

   // adjacency rows, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         rows[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_row_ff <= rows[rd_addr];
      end
   end

   // row valid bits: a row never written since the last clear or reset reads as empty
   always_comb begin
      row_valid_in = row_valid_ff;
      if (mem_ctl.clear) begin
         row_valid_in = '0;
      end else if (mem_ctl.wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (mem_ctl.rd_en) begin
         rd_valid_in = row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_row_ff : {NODES{1'b0}};

endmodule

// File: tb/bounded_hop_reachability_test.sv
`timescale 1ns / 1ps

module bounded_hop_reachability_test;

   localparam int NODE_TOTAL = 64;
   localparam logic [bhr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   // cycles without any transaction before the run is abandoned
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 210;

   // graph copy, node count and queue of expected answers
   class reach_scoreboard;
      logic [NODE_TOTAL-1:0]            adjacency [NODE_TOTAL];
      logic [bhr_pkg::NODE_COUNT_W-1:0] node_count;
      bhr_pkg::rsp_type                 answer_q [$];
      int                               failures;

      function new();
         foreach (adjacency[n]) adjacency[n] = '0;
         node_count = bhr_pkg::NODE_COUNT_RESET;
         failures = 0;
      endfunction

      function int pending();
         return answer_q.size();
      endfunction

      function bit every_node_linked();
         int lim;
         lim = (node_count > NODE_TOTAL) ? NODE_TOTAL : int'(node_count);
         for (int n = 0; n < lim; n++)
            if (adjacency[n] == '0) return 1'b0;
         return 1'b1;
      endfunction

      function bit reaches(logic [bhr_pkg::NODE_W-1:0] s, logic [bhr_pkg::NODE_W-1:0] t,
                           logic [bhr_pkg::HOP_W-1:0] hops);
         logic [NODE_TOTAL-1:0] frontier;
         logic [NODE_TOTAL-1:0] grown;
         int                    rounds;
         if (s == t) return 1'b1;
         if (hops == 0) return 1'b0;
         rounds = (hops > NODE_TOTAL - 1) ? NODE_TOTAL - 1 : int'(hops);
         frontier = '0;
         frontier[s] = 1'b1;
         // one hop per round along every edge
         for (int h = 0; h < rounds; h++) begin
            grown = frontier;
            for (int n = 0; n < NODE_TOTAL; n++)
               if (frontier[n]) grown |= adjacency[n];
            if (grown[t]) return 1'b1;
            if (grown == frontier) return 1'b0;
            frontier = grown;
         end
         return 1'b0;
      endfunction

      function void note_request(bhr_pkg::req_type r);
         bhr_pkg::rsp_type answer;
         answer.reachable = 1'b0;
         case (r.opcode)
            bhr_pkg::OP_CLEAR: begin
               foreach (adjacency[n]) adjacency[n] = '0;
            end
            bhr_pkg::OP_ADD_EDGE: begin
               adjacency[r.start_node][r.target_node] = 1'b1;
               adjacency[r.target_node][r.start_node] = 1'b1;
            end
            bhr_pkg::OP_QUERY: begin
               answer.reachable = reaches(r.start_node, r.target_node, r.hop_limit);
            end
            default: ;
         endcase
         answer.all_linked = every_node_linked();
         answer_q = {answer_q, answer};
      endfunction

      function void check_response(bhr_pkg::rsp_type got);
         bhr_pkg::rsp_type want;
         if (answer_q.size() == 0) begin
            $error("unexpected result transaction: reachable %0b all_linked %0b",
                   got.reachable, got.all_linked);
            failures++;
            return;
         end
         want = answer_q.pop_front();
         if (got.reachable !== want.reachable) begin
            $error("reachable: expected %0b, actual %0b", want.reachable, got.reachable);
            failures++;
         end
         if (got.all_linked !== want.all_linked) begin
            $error("all_linked: expected %0b, actual %0b", want.all_linked, got.all_linked);
            failures++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   bhr_pkg::req_type                 req_payload = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   bhr_pkg::rsp_type                 rsp_payload;
   logic                             csr_wr_en = 1'b0;
   logic [bhr_pkg::NODE_COUNT_W-1:0] csr_wr_data = '0;

   reach_scoreboard sb = new();

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  phase_items = 0;

   bounded_hop_reachability #(.NODES(NODE_TOTAL)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, long hold-off on request, checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offer one transaction, with a random gap first, and wait for acceptance
   task automatic send_item(logic [bhr_pkg::OPCODE_W-1:0] op,
                            logic [bhr_pkg::NODE_W-1:0] s,
                            logic [bhr_pkg::NODE_W-1:0] t,
                            logic [bhr_pkg::HOP_W-1:0] hops);
      bhr_pkg::req_type item;
      int               gap;
      item.opcode = op;
      item.start_node = s;
      item.target_node = t;
      item.hop_limit = hops;
      gap = 0;
      while (gap < 200 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      phase_items++;
   endtask

   // stop offering and let every expected result come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_node_count(logic [bhr_pkg::NODE_COUNT_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      sb.node_count = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // small graph in a window of nodes, then queries inside it
   task automatic cluster_sequence();
      logic [bhr_pkg::NODE_W-1:0] base;
      int                         span;
      int                         edges;
      int                         queries;
      logic [bhr_pkg::HOP_W-1:0]  hops;
      base = ($urandom_range(99) < 30) ? '0 : bhr_pkg::NODE_W'($urandom_range(0, 63));
      span = $urandom_range(2, 12);
      edges = $urandom_range(1, span + 2);
      queries = $urandom_range(2, 8);
      if ($urandom_range(99) < 70)
         send_item(bhr_pkg::OP_CLEAR, bhr_pkg::NODE_W'($urandom),
                   bhr_pkg::NODE_W'($urandom), bhr_pkg::HOP_W'($urandom));
      repeat (edges)
         send_item(bhr_pkg::OP_ADD_EDGE,
                   base + bhr_pkg::NODE_W'($urandom_range(0, span - 1)),
                   base + bhr_pkg::NODE_W'($urandom_range(0, span - 1)),
                   bhr_pkg::HOP_W'($urandom));
      repeat (queries) begin
         case ($urandom_range(3))
            0, 1: hops = bhr_pkg::HOP_W'($urandom_range(0, span));
            2: hops = bhr_pkg::HOP_W'($urandom_range(0, 255));
            default: hops = '0;
         endcase
         send_item(bhr_pkg::OP_QUERY,
                   base + bhr_pkg::NODE_W'($urandom_range(0, span - 1)),
                   base + bhr_pkg::NODE_W'($urandom_range(0, span - 1)), hops);
      end
   endtask

   // one path through all nodes in shuffled order; distances are known
   task automatic path_sequence();
      logic [bhr_pkg::NODE_W-1:0] order [NODE_TOTAL];
      logic [bhr_pkg::NODE_W-1:0] swap;
      int                         j;
      int                         a;
      int                         b;
      int                         distance;
      logic [bhr_pkg::HOP_W-1:0]  hops;
      for (int i = 0; i < NODE_TOTAL; i++) order[i] = bhr_pkg::NODE_W'(i);
      for (int i = NODE_TOTAL - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      send_item(bhr_pkg::OP_CLEAR, '0, '0, '0);
      for (int i = 0; i < NODE_TOTAL - 1; i++) begin
         if ($urandom_range(1))
            send_item(bhr_pkg::OP_ADD_EDGE, order[i], order[i + 1],
                      bhr_pkg::HOP_W'($urandom));
         else
            send_item(bhr_pkg::OP_ADD_EDGE, order[i + 1], order[i],
                      bhr_pkg::HOP_W'($urandom));
      end
      repeat (8) begin
         a = $urandom_range(0, NODE_TOTAL - 1);
         b = $urandom_range(0, NODE_TOTAL - 1);
         if ($urandom_range(2) == 0) begin
            a = 0;
            b = NODE_TOTAL - 1;
         end
         distance = (a > b) ? a - b : b - a;
         case ($urandom_range(4))
            0: hops = bhr_pkg::HOP_W'(distance);
            1: hops = (distance > 0) ? bhr_pkg::HOP_W'(distance - 1) : '0;
            2: hops = 8'd255;
            3: hops = bhr_pkg::HOP_W'(NODE_TOTAL - 1);
            default: hops = bhr_pkg::HOP_W'($urandom_range(0, 255));
         endcase
         send_item(bhr_pkg::OP_QUERY, order[a], order[b], hops);
      end
   endtask

   // fully random transactions, unused opcode included
   task automatic noise_sequence(int count);
      repeat (count)
         send_item(bhr_pkg::OPCODE_W'($urandom_range(0, 3)), bhr_pkg::NODE_W'($urandom),
                   bhr_pkg::NODE_W'($urandom), bhr_pkg::HOP_W'($urandom));
   endtask

   initial begin
      logic [bhr_pkg::NODE_COUNT_W-1:0] phase_count;
      int                               pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph, extremes, self edge, short chain, clear
      send_item(bhr_pkg::OP_QUERY, 6'd0, 6'd0, 8'd0);
      send_item(bhr_pkg::OP_QUERY, 6'd5, 6'd6, 8'd0);
      send_item(bhr_pkg::OP_QUERY, 6'd5, 6'd6, 8'd255);
      send_item(bhr_pkg::OP_ADD_EDGE, 6'd63, 6'd0, 8'd255);
      send_item(bhr_pkg::OP_ADD_EDGE, 6'd0, 6'd0, 8'd0);
      send_item(bhr_pkg::OP_QUERY, 6'd63, 6'd0, 8'd1);
      send_item(bhr_pkg::OP_QUERY, 6'd0, 6'd63, 8'd255);
      send_item(OP_UNUSED, 6'd63, 6'd63, 8'd255);
      send_item(bhr_pkg::OP_ADD_EDGE, 6'd10, 6'd11, 8'd0);
      send_item(bhr_pkg::OP_ADD_EDGE, 6'd12, 6'd11, 8'd0);
      send_item(bhr_pkg::OP_ADD_EDGE, 6'd12, 6'd13, 8'd0);
      send_item(bhr_pkg::OP_QUERY, 6'd10, 6'd13, 8'd2);
      send_item(bhr_pkg::OP_QUERY, 6'd10, 6'd13, 8'd3);
      send_item(bhr_pkg::OP_QUERY, 6'd13, 6'd10, 8'd255);
      send_item(bhr_pkg::OP_QUERY, 6'd10, 6'd63, 8'd255);
      send_item(bhr_pkg::OP_CLEAR, 6'd63, 6'd63, 8'd255);
      send_item(bhr_pkg::OP_QUERY, 6'd63, 6'd0, 8'd1);
      send_item(bhr_pkg::OP_QUERY, 6'd63, 6'd63, 8'd0);
      send_item(bhr_pkg::OP_QUERY, 6'd42, 6'd42, 8'd255);
      write_node_count(7'd1);
      send_item(bhr_pkg::OP_QUERY, 6'd0, 6'd1, 8'd1);
      send_item(bhr_pkg::OP_ADD_EDGE, 6'd0, 6'd0, 8'd0);
      send_item(bhr_pkg::OP_QUERY, 6'd0, 6'd0, 8'd0);

      // random phases, each setting a node count and an idling pattern
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: phase_count = 7'd64;
            1: phase_count = 7'd1;
            2: phase_count = 7'd0;
            3: phase_count = 7'd127;
            4: phase_count = bhr_pkg::NODE_COUNT_W'($urandom_range(1, 64));
            5: phase_count = 7'd65;
            6: phase_count = 7'd2;
            default: phase_count = 7'd64;
         endcase
         write_node_count(phase_count);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
            default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
         endcase
         phase_items = 0;
         // receiver holds off while the sender keeps offering
         if (p == 0 || p == 4) begin
            hold_request = 1'b1;
            noise_sequence(30);
         end
         while (phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60) cluster_sequence();
            else if (pick < 70) path_sequence();
            else noise_sequence($urandom_range(5, 10));
         end
      end

      // let the last results come back and watch for stray ones
      drain();
      repeat (300) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
